[rtl/mfd_pkg.sv]
package mfd_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int BASE_DELAY_W      = 24;
    localparam int MIX_DEPTH_W       = 16;
    localparam int FRAC_W            = 8;
    localparam int CFG_ADDR_W        = 1;
    localparam int CFG_DATA_W        = 24;
    localparam int IN_TDATA_W        = 48;
    localparam int OUT_TDATA_W       = 16;
    localparam int BUFFER_DEPTH_DFLT = 65536;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [MIX_DEPTH_W-1:0] MIX_DEPTH_RESET = 16'd16384;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BASE_DELAY = 1'b0,
        REG_MIX_DEPTH  = 1'b1
    } cfg_reg_t;

    // 1 + mod in Q1.15 as an unsigned 16-bit factor: 32768 + mod flips the sign bit
    function automatic logic [SAMPLE_W-1:0] one_plus(input logic [SAMPLE_W-1:0] m);
        one_plus = {~m[SAMPLE_W-1], m[SAMPLE_W-2:0]};
    endfunction

endpackage

[rtl/mfd_ram.sv]
module mfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/mfd_front.sv]
module mfd_front #(
    parameter int BUFFER_DEPTH = 65536
) (
    input  logic [mfd_pkg::BASE_DELAY_W-1:0] base_delay,
    input  logic [mfd_pkg::IN_TDATA_W-1:0]   s_tdata,
    // fields from lowest bit: n, f, in_sample, depth_mod
    output logic [2*mfd_pkg::SAMPLE_W+mfd_pkg::FRAC_W+$clog2(BUFFER_DEPTH)-1:0] entry
);
    import mfd_pkg::*;

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int PW   = BASE_DELAY_W + SAMPLE_W;
    localparam int DW   = PW - (SAMPLE_W - 1);
    localparam int CW   = (AW + FRAC_W > DW) ? AW + FRAC_W : DW;
    localparam logic [CW-1:0] MAXD = CW'(BUFFER_DEPTH - 1) << FRAC_W;

    logic [SAMPLE_W-1:0] in_sample;
    logic [SAMPLE_W-1:0] delay_mod;
    logic [SAMPLE_W-1:0] depth_mod;
    logic [PW-1:0]       prod;
    logic [CW-1:0]       d_ext;
    logic [CW-1:0]       d_clamp;

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign delay_mod = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign depth_mod = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

    // delay in samples with 8 fraction bits = base * (1 + mod)
    assign prod    = {{SAMPLE_W{1'b0}}, base_delay}
                   * {{BASE_DELAY_W{1'b0}}, one_plus(delay_mod)};
    assign d_ext   = CW'(prod[PW-1:SAMPLE_W-1]);
    assign d_clamp = (d_ext > MAXD) ? MAXD : d_ext;

    assign entry = {depth_mod, in_sample, d_clamp[FRAC_W-1:0], d_clamp[AW+FRAC_W-1:FRAC_W]};

endmodule

[rtl/mfd_queue.sv]
module mfd_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign ready    = (count_reg != FULLC);
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                slot_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/mfd_back.sv]
module mfd_back #(
    parameter int BUFFER_DEPTH = 65536
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [mfd_pkg::MIX_DEPTH_W-1:0]   mix_depth,
    input  logic                              q_valid,
    input  logic [2*mfd_pkg::SAMPLE_W+mfd_pkg::FRAC_W+$clog2(BUFFER_DEPTH)-1:0] q_entry,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mfd_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import mfd_pkg::*;

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int F_LO  = AW;
    localparam int X_LO  = AW + FRAC_W;
    localparam int G_LO  = X_LO + SAMPLE_W;
    localparam int DLY_W = SAMPLE_W + FRAC_W + 2;
    localparam int GN_W  = 2 * SAMPLE_W;
    localparam int PR_W  = DLY_W + GN_W + 1;
    // 8 interpolation fraction bits plus the Q.30 gain
    localparam int RND_S = FRAC_W + 2 * (SAMPLE_W - 1);
    localparam int WET_W = PR_W - RND_S;
    localparam int SUM_W = WET_W + 1;
    localparam logic [AW:0]      DEPTH_X = (AW+1)'(BUFFER_DEPTH);
    localparam logic [AW-1:0]    LAST_WP = AW'(BUFFER_DEPTH - 1);
    localparam logic [PR_W-1:0]  RND     = PR_W'(1) << (RND_S - 1);
    localparam logic [SAMPLE_W-1:0] SAT_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAT_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ_A,
        ST_READ_B,
        ST_LOAD_B,
        ST_MUL1,
        ST_MUL2,
        ST_ROUND,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [AW-1:0]            wp_reg;
    logic [AW:0]              fill_reg;
    logic [SAMPLE_W-1:0]      x_reg;
    logic [AW-1:0]            n_reg;
    logic [FRAC_W-1:0]        f_reg;
    logic [SAMPLE_W-1:0]      gmod_reg;
    logic [AW-1:0]            ia_reg;
    logic [AW-1:0]            ib_reg;
    logic                     a_ok_reg;
    logic                     b_ok_reg;
    logic [SAMPLE_W-1:0]      a_reg;
    logic [SAMPLE_W:0]        diff_reg;
    logic signed [DLY_W-1:0]  delayed_reg;
    logic [GN_W-1:0]          gain_reg;
    logic signed [PR_W-1:0]   prod_reg;
    logic [WET_W-1:0]         wet_reg;
    logic [SAMPLE_W-1:0]      out_reg;
    logic                     m_tvalid_reg;

    logic [AW:0]              wp_x;
    logic [AW:0]              n_x;
    logic [AW:0]              np1;
    logic [AW:0]              ia_next;
    logic [AW:0]              ib_next;
    logic [AW:0]              fill_next;
    logic [SAMPLE_W-1:0]      ram_rdata;
    logic [SAMPLE_W-1:0]      b_val;
    logic signed [DLY_W-1:0]  f_term;
    logic signed [DLY_W-1:0]  delayed_next;
    logic [GN_W-1:0]          gain_next;
    logic signed [PR_W-1:0]   prod_next;
    logic [PR_W-1:0]          rnd_sum;
    logic [SUM_W-1:0]         sum;
    logic [SAMPLE_W-1:0]      out_next;
    logic                     out_free;
    logic                     ram_we;
    logic [AW-1:0]            ram_raddr;

    mfd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (x_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_raddr = (state_reg == ST_READ_A) ? ia_reg : ib_reg;

    // tap addresses: a is n samples back, b one further
    assign wp_x    = {1'b0, wp_reg};
    assign n_x     = {1'b0, n_reg};
    assign np1     = n_x + (AW+1)'(1);
    assign ia_next = (wp_x >= n_x) ? wp_x - n_x : wp_x + DEPTH_X - n_x;
    assign ib_next = (wp_x >= np1) ? wp_x - np1 : wp_x + DEPTH_X - np1;
    // entries past the fill count were never written and read as zero
    assign fill_next = (fill_reg == DEPTH_X) ? fill_reg : fill_reg + (AW+1)'(1);

    assign b_val = b_ok_reg ? ram_rdata : '0;

    assign f_term = $signed({{(DLY_W-FRAC_W){1'b0}}, f_reg})
                  * $signed({{(DLY_W-SAMPLE_W-1){diff_reg[SAMPLE_W]}}, diff_reg});
    assign delayed_next = $signed({{2{a_reg[SAMPLE_W-1]}}, a_reg, {FRAC_W{1'b0}}}) + f_term;
    assign gain_next    = {{SAMPLE_W{1'b0}}, mix_depth}
                        * {{MIX_DEPTH_W{1'b0}}, one_plus(gmod_reg)};
    assign prod_next    = $signed({{(PR_W-DLY_W){delayed_reg[DLY_W-1]}}, delayed_reg})
                        * $signed({{(PR_W-GN_W){1'b0}}, gain_reg});

    assign rnd_sum = prod_reg + RND;
    assign sum     = {{(SUM_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg}
                   + {wet_reg[WET_W-1], wet_reg};

    always_comb begin
        if ((&sum[SUM_W-1:SAMPLE_W-1]) || !(|sum[SUM_W-1:SAMPLE_W-1])) begin
            out_next = sum[SAMPLE_W-1:0];
        end else if (sum[SUM_W-1]) begin
            out_next = SAT_LO;
        end else begin
            out_next = SAT_HI;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = q_valid && ((state_reg == ST_IDLE)
                                  || (state_reg == ST_OUT && out_free));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            if (q_pop) begin
                n_reg    <= q_entry[AW-1:0];
                f_reg    <= q_entry[F_LO+FRAC_W-1:F_LO];
                x_reg    <= q_entry[X_LO+SAMPLE_W-1:X_LO];
                gmod_reg <= q_entry[G_LO+SAMPLE_W-1:G_LO];
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    ia_reg    <= ia_next[AW-1:0];
                    ib_reg    <= ib_next[AW-1:0];
                    a_ok_reg  <= (n_x < fill_next);
                    b_ok_reg  <= (np1 < fill_next);
                    fill_reg  <= fill_next;
                    wp_reg    <= (wp_reg == LAST_WP) ? '0 : wp_reg + AW'(1);
                    state_reg <= ST_READ_A;
                end
                ST_READ_A: begin
                    state_reg <= ST_READ_B;
                end
                ST_READ_B: begin
                    a_reg     <= a_ok_reg ? ram_rdata : '0;
                    state_reg <= ST_LOAD_B;
                end
                ST_LOAD_B: begin
                    diff_reg  <= {b_val[SAMPLE_W-1], b_val} - {a_reg[SAMPLE_W-1], a_reg};
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    delayed_reg <= delayed_next;
                    gain_reg    <= gain_next;
                    state_reg   <= ST_MUL2;
                end
                ST_MUL2: begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    wet_reg   <= rnd_sum[PR_W-1:RND_S];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        out_reg      <= out_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= q_valid ? ST_WRITE : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

[rtl/modulated_fractional_delay.sv]
// Modulated fractional delay line with linear interpolation, mono 16-bit audio.
// Input channel s_*: one item per sample carrying the dry sample, the delay
// modulation and the depth modulation. Result channel m_*: one output sample
// per input item, in input order.
// Configuration: base_delay (index 0) and mix_depth (index 1) are written
// through cfg_wr_en / cfg_addr / cfg_wdata. The user must write them only
// while the block is idle; the block itself does not enforce this.
// The back-end sequencer takes one item at a time: it writes the sample into
// the store, reads the two taps one after the other through its single read
// port, then runs the interpolation and gain multipliers in registered steps.
// A two-entry queue sits between the front end (delay multiply and clamp) and
// the back end, so up to two items are taken while the back end is busy.
// When m_tready is low the finished sample waits in the output register and
// the back end holds; the queue keeps accepting until full.
// Reset: the write pointer and a fill counter are cleared; store entries not
// yet written read as zero, so no clearing pass is needed and items are
// accepted right after reset. Registers return to base_delay 0, mix_depth 0.5.
module modulated_fractional_delay #(
    parameter int BUFFER_DEPTH = mfd_pkg::BUFFER_DEPTH_DFLT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mfd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // in_sample [15:0], delay_mod [31:16], depth_mod [47:32]
    input  logic [mfd_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_sample [15:0]
    output logic [mfd_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import mfd_pkg::*;

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int ENTRY_W = 2 * SAMPLE_W + FRAC_W + AW;

    logic [BASE_DELAY_W-1:0] base_delay_reg;
    logic [MIX_DEPTH_W-1:0]  mix_depth_reg;
    logic [ENTRY_W-1:0]      front_entry;
    logic [ENTRY_W-1:0]      q_entry;
    logic                    q_valid;
    logic                    q_pop;
    logic                    q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_delay_reg <= '0;
            mix_depth_reg  <= MIX_DEPTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_BASE_DELAY: base_delay_reg <= cfg_wdata[BASE_DELAY_W-1:0];
                REG_MIX_DEPTH:  mix_depth_reg  <= cfg_wdata[MIX_DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    mfd_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .base_delay (base_delay_reg),
        .s_tdata    (s_tdata),
        .entry      (front_entry)
    );

    mfd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (front_entry),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_entry)
    );

    assign s_tready = q_ready;

    mfd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mix_depth (mix_depth_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfd_pkg::*;

    localparam int  STORE_DEPTH  = BUFFER_DEPTH_DFLT;
    localparam int  PTR_W        = $clog2(STORE_DEPTH);
    localparam int  RESET_CYCLES = 7;
    localparam int  SETTLE       = 30;
    localparam int  LONG_HOLD    = 400;
    localparam int  RAND_ITEMS   = 300;
    localparam int  LIMIT_CYCLES = 200_000;
    localparam logic [BASE_DELAY_W-1:0] BASE_DELAY_MAX = 24'd16776704;

    // in_sample sits in the lowest bits of tdata
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] depth_mod;
        logic signed [SAMPLE_W-1:0] delay_mod;
        logic signed [SAMPLE_W-1:0] in_sample;
    } audio_item_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // in_sample [15:0], delay_mod [31:16], depth_mod [47:32]
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // out_sample [15:0]
    logic [OUT_TDATA_W-1:0] m_tdata;

    modulated_fractional_delay u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    audio_item_t          sample_backlog[$];
    logic [SAMPLE_W-1:0]  out_sample_fifo[$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    bit                   tx_gap_en   = 1'b1;
    bit                   rx_stall_en = 1'b1;
    int                   hold_req    = 0;

    // local copy of the delay line
    logic signed [SAMPLE_W-1:0] sample_store[STORE_DEPTH];
    logic [PTR_W-1:0]           store_wp;
    logic [BASE_DELAY_W-1:0]    base_delay_q;
    logic [MIX_DEPTH_W-1:0]     mix_depth_q;

    function automatic logic [SAMPLE_W-1:0] predict_out_sample(audio_item_t it);
        longint           dly;
        longint           max_dly;
        logic [PTR_W-1:0] cur_wp;
        logic [PTR_W-1:0] tap_near;
        logic [PTR_W-1:0] tap_far;
        longint           frac;
        longint           near_val;
        longint           far_val;
        longint           delayed;
        longint           gain;
        longint           wet;
        longint           sum;
        cur_wp = store_wp;
        sample_store[cur_wp] = it.in_sample;
        store_wp = cur_wp + 1'b1;

        dly = (longint'(base_delay_q) * (32768 + longint'(it.delay_mod))) >> 15;
        max_dly = longint'(STORE_DEPTH - 1) << FRAC_W;
        if (dly > max_dly) dly = max_dly;
        frac = dly & ((1 << FRAC_W) - 1);
        tap_near = cur_wp - PTR_W'(dly >> FRAC_W);
        tap_far  = tap_near - 1'b1;
        near_val = longint'(sample_store[tap_near]);
        far_val  = longint'(sample_store[tap_far]);

        delayed = near_val * 256 + frac * (far_val - near_val);
        gain    = longint'(mix_depth_q) * (32768 + longint'(it.depth_mod));
        // arithmetic shift floors, so adding half first rounds half up
        wet     = (delayed * gain + (longint'(1) <<< 37)) >>> 38;
        sum     = longint'(it.in_sample) + wet;
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        return sum[SAMPLE_W-1:0];
    endfunction

    // sender: bursts of random length, random gaps in between when tx_gap_en is set
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (burst_left > 0) burst_left--;
                if (burst_left == 0 && tx_gap_en) gap_left = $urandom_range(0, 12);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (sample_backlog.size() > 0) begin
                    if (burst_left == 0) burst_left = $urandom_range(1, 16);
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_backlog.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: alternating ready and stall runs if rx_stall_en, plus a long hold on request
    int  hold_seen = 0;
    int  hold_left = 0;
    int  run_left  = 0;
    bit  run_ready = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_seen = hold_req;
            hold_left = 0;
            run_left  = 0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!rx_stall_en) begin
            m_tready <= 1'b1;
        end else begin
            if (run_left == 0) begin
                run_ready = !run_ready;
                run_left  = run_ready ? $urandom_range(1, 20) : $urandom_range(1, 6);
            end
            run_left--;
            m_tready <= run_ready;
        end
    end

    // monitor: register writes, input transfers into the predictor, result checks
    always @(posedge aclk) begin
        logic [SAMPLE_W-1:0] want;
        if (!aresetn) begin
            foreach (sample_store[i]) sample_store[i] = '0;
            store_wp     = '0;
            base_delay_q = '0;
            mix_depth_q  = MIX_DEPTH_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_BASE_DELAY: base_delay_q = cfg_wdata[BASE_DELAY_W-1:0];
                    REG_MIX_DEPTH:  mix_depth_q  = cfg_wdata[MIX_DEPTH_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (out_sample_fifo.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected out_sample transfer, actual %0d", $time,
                             $signed(m_tdata));
                end else begin
                    want = out_sample_fifo.pop_front();
                    if (m_tdata !== want) begin
                        mismatch_count++;
                        $display("%0t: out_sample expected %0d actual %0d", $time,
                                 $signed(want), $signed(m_tdata));
                    end
                end
            end
            if (s_tvalid && s_tready)
                out_sample_fifo.push_back(predict_out_sample(audio_item_t'(s_tdata)));
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("modulated_fractional_delay: mismatch");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] random_q15();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_W'($urandom_range(0, 255)) - 16'd128;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic void push_item(logic [SAMPLE_W-1:0] smp, logic [SAMPLE_W-1:0] dmod,
                                      logic [SAMPLE_W-1:0] gmod);
        audio_item_t it;
        it.in_sample = smp;
        it.delay_mod = dmod;
        it.depth_mod = gmod;
        sample_backlog.push_back(it);
    endfunction

    function automatic void push_random(int count);
        for (int i = 0; i < count; i++)
            push_item(random_q15(), random_q15(), random_q15());
    endfunction

    task automatic wait_drained();
        do @(negedge aclk);
        while (sample_backlog.size() != 0 || s_tvalid || out_sample_fifo.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // upper bits of a mix_depth write are don't-care, so fill them with noise
    task automatic set_delay_and_depth(logic [BASE_DELAY_W-1:0] base,
                                       logic [MIX_DEPTH_W-1:0] mix);
        write_reg(REG_BASE_DELAY, base);
        write_reg(REG_MIX_DEPTH, {8'($urandom), mix});
        @(negedge aclk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero delay at reset settings: saturation at both rails, gain extremes
        push_item(16'h0000, 16'h0000, 16'h0000);
        push_item(16'h7FFF, 16'h0000, 16'h0000);
        push_item(16'h8000, 16'h0000, 16'h0000);
        push_item(16'h7FFF, 16'h0000, 16'h7FFF);
        push_item(16'h8000, 16'h8000, 16'h8000);
        push_item(16'h0001, 16'h7FFF, 16'h8000);
        push_item(16'hFFFF, 16'h8000, 16'h7FFF);
        push_item(16'h5555, 16'hAAAA, 16'h5555);
        wait_drained();

        // base delay of 3.5 samples at full gain: interpolation between opposite rails
        set_delay_and_depth(24'h000380, 16'hFFFF);
        push_item(16'h7FFF, 16'h0000, 16'h0000);
        push_item(16'h8000, 16'h0000, 16'h7FFF);
        push_item(16'h7FFF, 16'h7FFF, 16'h8000);
        push_item(16'h8000, 16'h8000, 16'h0000);
        push_item(16'h5A5A, 16'h4000, 16'hC000);
        push_item(16'hA5A5, 16'hC000, 16'h4000);
        push_item(16'h0000, 16'h2AAA, 16'h7FFF);
        push_item(16'h7FFF, 16'hD555, 16'h7FFF);
        wait_drained();

        // near-maximum base delay: clamped, unclamped and zero delay
        set_delay_and_depth(BASE_DELAY_MAX, 16'h0000);
        push_item(16'h1234, 16'h7FFF, 16'h7FFF);
        push_item(16'hEDCB, 16'h0000, 16'h8000);
        push_item(16'h7FFF, 16'h8000, 16'h0000);
        wait_drained();
        set_delay_and_depth(BASE_DELAY_MAX, 16'hFFFF);
        push_item(16'h8000, 16'h7FFF, 16'h7FFF);
        push_item(16'h7FFF, 16'h0001, 16'h0000);
        push_item(16'h0100, 16'h8000, 16'h7FFF);
        wait_drained();

        // short delays with a long receiver hold
        set_delay_and_depth(24'($urandom_range(0, 64 * 256)), 16'($urandom));
        push_random(RAND_ITEMS);
        hold_req++;
        wait_drained();

        set_delay_and_depth(BASE_DELAY_MAX, 16'h0000);
        push_random(RAND_ITEMS);
        wait_drained();

        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        set_delay_and_depth(24'($urandom), 16'hFFFF);
        push_random(RAND_ITEMS);
        wait_drained();
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;

        set_delay_and_depth(24'h000000, 16'($urandom));
        push_random(RAND_ITEMS);
        wait_drained();

        for (int p = 0; p < 2; p++) begin
            set_delay_and_depth(24'($urandom_range(0, 16 * 256)), 16'($urandom));
            push_random(RAND_ITEMS);
            wait_drained();
        end

        if (out_sample_fifo.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d out_sample results never arrived", $time,
                     out_sample_fifo.size());
        end
        if (mismatch_count == 0) begin
            $display("modulated_fractional_delay: match");
        end else begin
            $display("modulated_fractional_delay: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mfd_pkg.sv
rtl/mfd_ram.sv
rtl/mfd_front.sv
rtl/mfd_queue.sv
rtl/mfd_back.sv
rtl/modulated_fractional_delay.sv
bench/tb.sv
